// ----- rtl/core/ipacl_pkg.sv -----
// ----------------------------------------------------------------------------
// ipacl_pkg: shared types and constants of the prefix access list
// Table geometry, operation and status codes, the controller states and
// the structs that travel between the controller and the rule cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ipacl_pkg;

    // table geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // fixed widths of the result fields
    localparam int POS_W  = 4;
    localparam int RCNT_W = 5;
    localparam int STAT_W = 3;

    // stream payload widths
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DEFAULT_ALLOW = 1'b0;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE         = 3'd0,
        STAT_DUP_AGREE    = 3'd1,
        STAT_DUP_CONFLICT = 3'd2,
        STAT_INVALID      = 3'd3,
        STAT_FULL         = 3'd4,
        STAT_NOT_FOUND    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CMP,
        FSM_EXEC
    } fsm_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_REMOVE
    } shift_t;

    typedef struct packed {
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] mask;
        logic              allow;
    } rule_t;

    // command broadcast to every cell
    typedef struct packed {
        shift_t           kind;
        logic [IDX_W-1:0] pos;
        rule_t            rule;
    } cell_cmd_t;

    // compare results each cell reports back
    typedef struct packed {
        logic hit;
        logic equal;
        logic precede;
    } cell_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/ipacl_cell.sv -----
// ----------------------------------------------------------------------------
// ipacl_cell: one rule slot of the access list
// Holds one rule, compares it against the current query and registers the
// result, and on insert or remove shifts a rule in from a neighbor or loads the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_cell (
    input  wire logic                             aclk,
    input  wire logic [ipacl_pkg::IDX_W-1:0]      cell_idx,
    input  wire ipacl_pkg::cell_cmd_t             cmd,
    input  wire ipacl_pkg::rule_t                 left_rule,
    input  wire ipacl_pkg::rule_t                 right_rule,
    input  wire logic [ipacl_pkg::WORD_W-1:0]     q_addr,
    input  wire logic [ipacl_pkg::WORD_W-1:0]     q_mask,
    output ipacl_pkg::rule_t                      rule,
    output ipacl_pkg::cell_flags_t                flags
);

    ipacl_pkg::rule_t       rule_reg;
    ipacl_pkg::rule_t       rule_next;
    ipacl_pkg::cell_flags_t flags_reg;
    ipacl_pkg::cell_flags_t flags_next;

    // shift control: insert pulls from the left, remove from the right
    always_comb begin
        rule_next = rule_reg;
        case (cmd.kind)
            ipacl_pkg::SH_INSERT: begin
                if (cell_idx > cmd.pos) begin
                    rule_next = left_rule;
                end else if (cell_idx == cmd.pos) begin
                    rule_next = cmd.rule;
                end
            end
            ipacl_pkg::SH_REMOVE: begin
                if (cell_idx >= cmd.pos) begin
                    rule_next = right_rule;
                end
            end
            default: begin
                rule_next = rule_reg;
            end
        endcase
    end

    // compare stored rule against the query
    always_comb begin
        flags_next.hit     = (rule_reg.addr & rule_reg.mask) == (q_addr & rule_reg.mask);
        flags_next.equal   = (rule_reg.mask == q_mask) && (rule_reg.addr == q_addr);
        flags_next.precede = (q_mask > rule_reg.mask) ||
                             ((q_mask == rule_reg.mask) && (q_addr > rule_reg.addr));
    end

    always_ff @(posedge aclk) begin
        rule_reg  <= rule_next;
        flags_reg <= flags_next;
    end

    assign rule  = rule_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ipacl_pick.sv -----
// ----------------------------------------------------------------------------
// ipacl_pick: first-set picker over the cell flags
// Returns the lowest position whose bit is set, and whether any bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_pick (
    input  wire logic [ipacl_pkg::DEPTH-1:0] vec,
    output logic                             found,
    output logic [ipacl_pkg::IDX_W-1:0]      idx
);

    // scan from the top so the lowest set bit wins
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = ipacl_pkg::DEPTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                found = 1'b1;
                idx   = ipacl_pkg::IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ip_prefix_access_list.sv -----
// ----------------------------------------------------------------------------
// ip_prefix_access_list: IPv4 prefix access list with sorted rule cells
// Lookup, add and remove over a row of rule cells kept in mask/address order.
// ----------------------------------------------------------------------------
// Usage:
//   s_ beats carry one operation each: s_tuser is the operation code, s_tdata
//   the address, mask and allow bit. m_ beats carry one result per operation.
//   The APB port sets default_allow, the lookup answer while the table is
//   empty; write it only while no operation is in flight.
// Operation steps:
//   the query is registered, every cell compares it with its rule and
//   registers the flags, then the controller picks the first flagged cell,
//   shifts the row for insert or remove and loads the result register.
//   The next beat is taken only after the result register is loaded.
// Stall:
//   while m_tready is low the finished result is held and the next beat is
//   still accepted and compared; it waits in the decide step until the
//   result register frees up.
// Reset:
//   aresetn empties the table (rule count 0), clears default_allow and the
//   result valid flag. Rule slots are not cleared; slots above the count are
//   never used.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_prefix_access_list (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // operation beats
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] ip_address, [63:32] prefix_mask, [64] allow_bit, [71:65] zero
    input  wire logic [ipacl_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] operation
    input  wire logic [ipacl_pkg::S_USER_W-1:0]      s_tuser,
    // result beats
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] verdict, [1] matched, [5:2] match_position, [8:6] status,
    // [13:9] rule_count, [15:14] zero
    output logic [ipacl_pkg::M_DATA_W-1:0]           m_tdata,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ipacl_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ipacl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ipacl_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                     pready
);

    localparam int DEPTH = ipacl_pkg::DEPTH;
    localparam int IDX_W = ipacl_pkg::IDX_W;
    localparam int CNT_W = ipacl_pkg::CNT_W;

    // controller state
    ipacl_pkg::fsm_t state_reg;
    ipacl_pkg::fsm_t state_next;

    // registered query
    logic [1:0]                     q_op_reg;
    logic [ipacl_pkg::WORD_W-1:0]   q_addr_reg;
    logic [ipacl_pkg::WORD_W-1:0]   q_mask_reg;
    logic                           q_allow_reg;
    logic                           q_invalid_reg;

    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           default_allow_reg;

    logic                           m_tvalid_reg;
    logic [ipacl_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic s_accept;
    logic out_free;
    logic exec_fire;
    logic cfg_write;

    // cell row
    ipacl_pkg::rule_t       rules     [DEPTH];
    ipacl_pkg::cell_flags_t flags     [DEPTH];
    ipacl_pkg::cell_cmd_t   cell_cmd;
    ipacl_pkg::shift_t      shift_kind;
    logic [IDX_W-1:0]       shift_pos;

    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] hit_vec;
    logic [DEPTH-1:0] equal_vec;
    logic [DEPTH-1:0] precede_vec;

    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic             equal_found;
    logic [IDX_W-1:0] equal_idx;
    logic             precede_found;
    logic [IDX_W-1:0] precede_idx;

    // decision outputs
    logic                       res_verdict;
    logic                       res_matched;
    logic [IDX_W-1:0]           res_idx;
    ipacl_pkg::status_t         res_status;
    logic [IDX_W+ipacl_pkg::POS_W-1:0]  pos_wide;
    logic [CNT_W+ipacl_pkg::RCNT_W-1:0] cnt_wide;

    logic [ipacl_pkg::WORD_W-1:0] in_addr;
    logic [ipacl_pkg::WORD_W-1:0] in_mask;
    logic [ipacl_pkg::WORD_W-1:0] in_masked;

    assign in_addr   = s_tdata[31:0];
    assign in_mask   = s_tdata[63:32];
    assign in_masked = in_addr & in_mask;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ipacl_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = ipacl_pkg::FSM_CMP;
                end
            end
            ipacl_pkg::FSM_CMP: begin
                state_next = ipacl_pkg::FSM_EXEC;
            end
            ipacl_pkg::FSM_EXEC: begin
                if (out_free) begin
                    state_next = ipacl_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = ipacl_pkg::FSM_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == ipacl_pkg::FSM_IDLE);
        exec_fire = (state_reg == ipacl_pkg::FSM_EXEC) && out_free;
    end

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipacl_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // query capture; add keys are stored masked
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            q_op_reg      <= s_tuser;
            q_addr_reg    <= (ipacl_pkg::op_t'(s_tuser) == ipacl_pkg::OP_ADD) ?
                             in_masked : in_addr;
            q_mask_reg    <= in_mask;
            q_allow_reg   <= s_tdata[64];
            q_invalid_reg <= (in_masked == '0) && (in_mask != '0);
        end
    end

    // rule cells, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ipacl_pkg::rule_t left_rule;
        ipacl_pkg::rule_t right_rule;

        if (i == 0) begin : g_first
            assign left_rule = rules[i];
        end else begin : g_inner_left
            assign left_rule = rules[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_rule = rules[i];
        end else begin : g_inner_right
            assign right_rule = rules[i+1];
        end

        ipacl_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .cmd        (cell_cmd),
            .left_rule  (left_rule),
            .right_rule (right_rule),
            .q_addr     (q_addr_reg),
            .q_mask     (q_mask_reg),
            .rule       (rules[i]),
            .flags      (flags[i])
        );

        assign valid_vec[i]   = CNT_W'(i) < count_reg;
        assign hit_vec[i]     = flags[i].hit && valid_vec[i];
        assign equal_vec[i]   = flags[i].equal && valid_vec[i];
        assign precede_vec[i] = flags[i].precede && valid_vec[i];
    end

    ipacl_pick u_pick_hit (
        .vec   (hit_vec),
        .found (hit_found),
        .idx   (hit_idx)
    );

    ipacl_pick u_pick_equal (
        .vec   (equal_vec),
        .found (equal_found),
        .idx   (equal_idx)
    );

    ipacl_pick u_pick_precede (
        .vec   (precede_vec),
        .found (precede_found),
        .idx   (precede_idx)
    );

    // operation decision from the registered flags
    always_comb begin
        res_verdict = 1'b0;
        res_matched = 1'b0;
        res_idx     = '0;
        res_status  = ipacl_pkg::STAT_DONE;
        shift_kind  = ipacl_pkg::SH_HOLD;
        shift_pos   = '0;
        count_next  = count_reg;
        case (ipacl_pkg::op_t'(q_op_reg))
            ipacl_pkg::OP_LOOKUP: begin
                if (count_reg == '0) begin
                    res_verdict = default_allow_reg;
                end else if (hit_found) begin
                    res_verdict = rules[hit_idx].allow;
                    res_matched = 1'b1;
                    res_idx     = hit_idx;
                end else begin
                    res_status  = ipacl_pkg::STAT_NOT_FOUND;
                end
            end
            ipacl_pkg::OP_ADD: begin
                if (q_invalid_reg) begin
                    res_status = ipacl_pkg::STAT_INVALID;
                end else if (equal_found) begin
                    res_matched = 1'b1;
                    res_idx     = equal_idx;
                    if (rules[equal_idx].allow == q_allow_reg) begin
                        res_verdict = 1'b1;
                        res_status  = ipacl_pkg::STAT_DUP_AGREE;
                    end else begin
                        res_status  = ipacl_pkg::STAT_DUP_CONFLICT;
                    end
                end else if (count_reg == CNT_W'(DEPTH)) begin
                    res_status = ipacl_pkg::STAT_FULL;
                end else begin
                    res_verdict = 1'b1;
                    shift_kind  = ipacl_pkg::SH_INSERT;
                    shift_pos   = precede_found ? precede_idx : count_reg[IDX_W-1:0];
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            ipacl_pkg::OP_REMOVE: begin
                if (equal_found) begin
                    res_verdict = 1'b1;
                    res_matched = 1'b1;
                    res_idx     = equal_idx;
                    shift_kind  = ipacl_pkg::SH_REMOVE;
                    shift_pos   = equal_idx;
                    count_next  = count_reg - CNT_W'(1);
                end else begin
                    res_status  = ipacl_pkg::STAT_NOT_FOUND;
                end
            end
            default: begin
                res_verdict = 1'b0;
            end
        endcase
    end

    // shift only on the decide cycle that retires
    always_comb begin
        cell_cmd.kind = exec_fire ? shift_kind : ipacl_pkg::SH_HOLD;
        cell_cmd.pos  = shift_pos;
        cell_cmd.rule = '{addr: q_addr_reg, mask: q_mask_reg, allow: q_allow_reg};
    end

    // rule count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec_fire) begin
            count_reg <= count_next;
        end
    end

    // fit position and count into the result fields
    assign pos_wide = {{ipacl_pkg::POS_W{1'b0}}, res_idx};
    assign cnt_wide = {{ipacl_pkg::RCNT_W{1'b0}}, count_next};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_tdata_reg <= {2'b00,
                            cnt_wide[ipacl_pkg::RCNT_W-1:0],
                            res_status,
                            pos_wide[ipacl_pkg::POS_W-1:0],
                            res_matched,
                            res_verdict};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == ipacl_pkg::REG_DEFAULT_ALLOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_allow_reg <= 1'b0;
        end else if (cfg_write) begin
            default_allow_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ipacl_pkg::REG_DEFAULT_ALLOW) begin
            prdata[0] = default_allow_reg;
        end
    end

    // the table never holds more rules than it has cells
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("rule count beyond table depth");

    // the count only moves when a decide step retires, and by one at most
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ($past(exec_fire) &&
             ((count_reg == $past(count_reg) + CNT_W'(1)) ||
              (count_reg == $past(count_reg) - CNT_W'(1)))))
        else $error("rule count changed outside a decide step");

    // an accepted beat goes straight to the compare step
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ipacl_pkg::FSM_CMP))
        else $error("accepted beat did not enter compare");

    // a new result is only loaded from the decide step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ipacl_pkg::FSM_EXEC))
        else $error("result appeared without a decide step");

    // the row never shifts outside a retiring decide step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_cmd.kind != ipacl_pkg::SH_HOLD) |-> exec_fire)
        else $error("cell row shifted outside a decide step");

endmodule

`default_nettype wire
